@@ rtl/nfbch_pkg.sv @@
// Package for the navigation subframe BCH(15,11) interleave encoder.
// Transaction types, state encoding, divisor constants and encode functions.
// No dependencies; used by the divider, the encoder top and its testbench.
`default_nettype none

package nfbch_pkg;

    typedef struct packed {
        logic        mode;
        logic [11:0] table_addr;
        logic [21:0] table_word;
        logic [29:0] ms_of_week;
        logic [5:0]  sat_id;
    } t_in_item;

    typedef struct packed {
        logic [29:0] code_word;
        logic [3:0]  word_index;
        logic        last;
        logic        bad_satellite;
    } t_result;

    localparam int DIVIDEND_W = 30;
    localparam int DIVISOR_W  = 10;
    localparam int BASE_W     = 12;
    localparam int SOW_W      = 20;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BASE,
        ST_WORD0,
        ST_READ,
        ST_EMIT,
        ST_BAD
    } t_state;

    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [29:0] WEEK_MS  = 30'd604800000;
    localparam logic [10:0] PREAMBLE = 11'h712;

    localparam logic [DIVISOR_W-1:0] DIV_MS_D1    = 10'd1000;
    localparam logic [DIVISOR_W-1:0] DIV_SUB_D1   = 10'd6;
    localparam logic [DIVISOR_W-1:0] DIV_SUBFRAMES = 10'd5;
    localparam logic [DIVISOR_W-1:0] DIV_PAGES_D1 = 10'd24;
    localparam logic [DIVISOR_W-1:0] DIV_MS_D2    = 10'd600;
    localparam logic [DIVISOR_W-1:0] DIV_PAGES_D2 = 10'd10;

    localparam logic [1:0] PASS_LAST_D1 = 2'd3;
    localparam logic [1:0] PASS_LAST_D2 = 2'd2;

    localparam logic [5:0] SAT_D1_LO = 6'd6;
    localparam logic [5:0] SAT_D1_HI = 6'd58;
    localparam logic [5:0] SAT_D2_LO_HI = 6'd5;
    localparam logic [5:0] SAT_D2_HI_OFS = 6'd54;

    localparam logic [BASE_W-1:0] D1_ROW_WORDS = 12'd27;
    localparam logic [BASE_W-1:0] D1_SUB_WORDS = 12'd9;
    localparam logic [BASE_W-1:0] ALM_PAGES    = 12'd24;
    localparam logic [BASE_W-1:0] ALM_WORDS    = 12'd432;
    localparam logic [BASE_W-1:0] D2_ROW_WORDS = 12'd40;
    localparam logic [BASE_W-1:0] D2_PAGE_WORDS = 12'd4;

    localparam logic [3:0] D1_NWORDS = 4'd9;
    localparam logic [3:0] D2_NWORDS = 4'd4;
    localparam logic [3:0] LAST_IDX  = 4'd9;

    localparam logic [14:0] BCH_MASK [4] = '{15'h7ac0, 15'h3d60, 15'h1eb0, 15'h7590};

    function automatic logic [3:0] bch_parity(input logic [10:0] info);
        logic [14:0] w;
        logic [3:0]  p;
        w = {info, 4'b0000};
        for (int k = 0; k < 4; k++) begin
            p[3-k] = ^(w & BCH_MASK[k]);
        end
        return p;
    endfunction

    function automatic logic [29:0] encode_word(input logic [21:0] w);
        logic [14:0] hi;
        logic [14:0] lo;
        logic [29:0] r;
        hi = {w[21:11], bch_parity(w[21:11])};
        lo = {w[10:0], bch_parity(w[10:0])};
        for (int k = 0; k < 15; k++) begin
            r[2*k+1] = hi[k];
            r[2*k]   = lo[k];
        end
        return r;
    endfunction

    function automatic logic [29:0] encode_first(input logic [2:0] sub,
                                                 input logic [7:0] sow_hi);
        return {PREAMBLE, 4'b0000, sub, sow_hi, bch_parity({sub, sow_hi})};
    endfunction

endpackage

`default_nettype wire

@@ rtl/nfbch_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the message store; no package dependency.
`default_nettype none

module nfbch_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/nfbch_sdiv.sv @@
// Bit-serial restoring divider: 30-bit dividend by a 10-bit constant divisor.
// One quotient bit per cycle. Depends on nfbch_pkg.
`default_nettype none

module nfbch_sdiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nfbch_pkg::t_div_req i_req,
    output nfbch_pkg::t_div_rsp    o_rsp
);

    localparam int CNT_W = $clog2(nfbch_pkg::DIVIDEND_W);

    logic                                r_run;
    logic                                r_done;
    logic [CNT_W-1:0]                    r_cnt;
    logic [nfbch_pkg::DIVIDEND_W-1:0]    r_quo;
    logic [nfbch_pkg::DIVISOR_W-1:0]     r_rem;
    logic [nfbch_pkg::DIVISOR_W-1:0]     r_dvs;
    logic [nfbch_pkg::DIVISOR_W:0]       trial;
    logic                                fits;

    assign trial = {r_rem, r_quo[nfbch_pkg::DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(nfbch_pkg::DIVIDEND_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[nfbch_pkg::DIVIDEND_W-2:0], fits};
            r_rem <= fits ? nfbch_pkg::DIVISOR_W'(trial - {1'b0, r_dvs})
                          : trial[nfbch_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

`ifndef SYNTHESIS
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run))
        else $error("divider done without a running division");
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");
    a_no_start_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_req.start)
        else $error("divider restarted while running");
`endif

endmodule

`default_nettype wire

@@ rtl/nav_frame_bch_interleave_encoder.sv @@
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+----------------------------------------
// request   | i_start, o_busy, i_in          | taken at an edge with i_start & !o_busy
// result    | o_valid, o_result              | one-cycle strobe, no back-pressure
//
// A store write is done at acceptance. A frame request runs the bit-serial
// divider for four passes (D1) or three (D2), each a load, 30 shifts and done,
// then a base step and word 0, then nine more words, each a store read, then
// an encode; o_busy stays high throughout. A bad satellite gives its single
// error result from the ST_BAD state. After reset the store is cleared one
// entry a cycle with o_busy high. Results cannot be stalled. Depends on
// nfbch_pkg, nfbch_ram, nfbch_sdiv.
`default_nettype none

module nav_frame_bch_interleave_encoder #(
    parameter int STORE_DEPTH = 4096,
    parameter int D1_SATS     = 53,
    parameter int D2_SATS     = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire nfbch_pkg::t_in_item i_in,
    output logic                     o_busy,
    output logic                     o_valid,
    output nfbch_pkg::t_result       o_result
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int BW = nfbch_pkg::BASE_W;
    localparam int ALM_BASE = D1_SATS * 27;
    localparam logic [BW-1:0] D1_ALM_BASE = BW'(ALM_BASE);
    localparam logic [BW-1:0] D2_BASE     = BW'(ALM_BASE + 432);

    nfbch_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [29:0]       r_ms, n_ms;
    logic              r_d1, n_d1;
    logic [5:0]        r_row, n_row;
    logic [1:0]        r_pass, n_pass;
    logic [29:0]       r_q, n_q;
    logic [nfbch_pkg::SOW_W-1:0] r_sow, n_sow;
    logic [2:0]        r_sub, n_sub;
    logic [4:0]        r_page, n_page;
    logic [BW-1:0]     r_base, n_base;
    logic [3:0]        r_nwords, n_nwords;
    logic [3:0]        r_idx, n_idx;
    logic              r_rd_ok, n_rd_ok;
    logic              r_valid, n_valid;
    nfbch_pkg::t_result r_res, n_res;

    nfbch_pkg::t_div_req div_req;
    nfbch_pkg::t_div_rsp div_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [21:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [21:0]   ram_rdata;
    logic [BW-1:0] rd_addr;

    logic          acc;
    logic [5:0]    sat;
    logic          sat_d1;
    logic [5:0]    row_d1;
    logic [5:0]    row_d2;
    logic          sat_bad;
    logic [21:0]   payload;

    nfbch_ram #(
        .WIDTH(22),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    nfbch_sdiv u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign acc    = i_start && (r_state == nfbch_pkg::ST_IDLE);
    assign sat    = i_in.sat_id;
    assign sat_d1 = (sat >= nfbch_pkg::SAT_D1_LO) && (sat <= nfbch_pkg::SAT_D1_HI);
    assign row_d1 = sat - nfbch_pkg::SAT_D1_LO;
    assign row_d2 = (sat <= nfbch_pkg::SAT_D2_LO_HI) ? sat - 6'd1
                                                      : sat - nfbch_pkg::SAT_D2_HI_OFS;
    assign sat_bad = (sat == 6'd0)
                  || (sat_d1 ? (32'(row_d1) >= D1_SATS) : (32'(row_d2) >= D2_SATS));

    assign rd_addr   = r_base + BW'(r_idx) - BW'(1);
    assign ram_raddr = AW'(rd_addr);

    always_comb begin
        div_req.start    = (r_state == nfbch_pkg::ST_DIV_START);
        div_req.dividend = r_q;
        div_req.divisor  = nfbch_pkg::DIV_MS_D1;
        if (r_pass == 2'd0) begin
            div_req.dividend = r_ms;
        end else if (!r_d1 && r_pass == 2'd2) begin
            div_req.dividend = {1'b0, r_q[29:1]};
        end
        unique case ({r_d1, r_pass})
            3'b100:  div_req.divisor = nfbch_pkg::DIV_MS_D1;
            3'b101:  div_req.divisor = nfbch_pkg::DIV_SUB_D1;
            3'b110:  div_req.divisor = nfbch_pkg::DIV_SUBFRAMES;
            3'b111:  div_req.divisor = nfbch_pkg::DIV_PAGES_D1;
            3'b000:  div_req.divisor = nfbch_pkg::DIV_MS_D2;
            3'b001:  div_req.divisor = nfbch_pkg::DIV_SUBFRAMES;
            3'b010:  div_req.divisor = nfbch_pkg::DIV_PAGES_D2;
            default: div_req.divisor = nfbch_pkg::DIV_PAGES_D2;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_ms     = r_ms;
        n_d1     = r_d1;
        n_row    = r_row;
        n_pass   = r_pass;
        n_q      = r_q;
        n_sow    = r_sow;
        n_sub    = r_sub;
        n_page   = r_page;
        n_base   = r_base;
        n_nwords = r_nwords;
        n_idx    = r_idx;
        n_rd_ok  = r_rd_ok;
        n_valid  = 1'b0;
        n_res    = r_res;
        ram_we    = 1'b0;
        ram_waddr = AW'(i_in.table_addr);
        ram_wdata = i_in.table_word;
        payload   = '0;

        unique case (r_state)
            nfbch_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(STORE_DEPTH - 1)) begin
                    n_state = nfbch_pkg::ST_IDLE;
                end
            end
            nfbch_pkg::ST_IDLE: begin
                if (acc && i_in.mode == nfbch_pkg::MODE_WRITE) begin
                    ram_we = (32'(i_in.table_addr) < STORE_DEPTH);
                end else if (acc) begin
                    n_ms   = (i_in.ms_of_week >= nfbch_pkg::WEEK_MS)
                           ? i_in.ms_of_week - nfbch_pkg::WEEK_MS : i_in.ms_of_week;
                    n_d1   = sat_d1;
                    n_row  = sat_d1 ? row_d1 : row_d2;
                    n_pass = 2'd0;
                    n_state = sat_bad ? nfbch_pkg::ST_BAD : nfbch_pkg::ST_DIV_START;
                end
            end
            nfbch_pkg::ST_DIV_START: begin
                n_state = nfbch_pkg::ST_DIV_WAIT;
            end
            nfbch_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_q = div_rsp.quotient;
                    case ({r_d1, r_pass})
                        3'b100: n_sow = div_rsp.quotient[nfbch_pkg::SOW_W-1:0];
                        3'b110: n_sub = div_rsp.remainder[2:0] + 3'd1;
                        3'b111: n_page = div_rsp.remainder[4:0];
                        3'b001: begin
                            n_sub = div_rsp.remainder[2:0] + 3'd1;
                            n_sow = div_rsp.quotient[nfbch_pkg::SOW_W-1:0]
                                  + {div_rsp.quotient[nfbch_pkg::SOW_W-2:0], 1'b0};
                        end
                        3'b010: n_page = div_rsp.remainder[4:0];
                        default: ;
                    endcase
                    if (r_pass == (r_d1 ? nfbch_pkg::PASS_LAST_D1
                                        : nfbch_pkg::PASS_LAST_D2)) begin
                        n_state = nfbch_pkg::ST_BASE;
                    end else begin
                        n_pass  = r_pass + 2'd1;
                        n_state = nfbch_pkg::ST_DIV_START;
                    end
                end
            end
            nfbch_pkg::ST_BASE: begin
                if (r_d1) begin
                    n_nwords = nfbch_pkg::D1_NWORDS;
                    if (r_sub > 3'd3) begin
                        n_base = D1_ALM_BASE
                               + (BW'(r_sub - 3'd4) * nfbch_pkg::ALM_PAGES + BW'(r_page))
                               * nfbch_pkg::D1_SUB_WORDS;
                    end else begin
                        n_base = BW'(r_row) * nfbch_pkg::D1_ROW_WORDS
                               + BW'(r_sub - 3'd1) * nfbch_pkg::D1_SUB_WORDS;
                    end
                end else if (r_sub == 3'd1) begin
                    n_nwords = nfbch_pkg::D2_NWORDS;
                    n_base   = D2_BASE + BW'(r_row) * nfbch_pkg::D2_ROW_WORDS
                             + BW'(r_page) * nfbch_pkg::D2_PAGE_WORDS;
                end else begin
                    n_nwords = 4'd0;
                    n_base   = '0;
                end
                n_state = nfbch_pkg::ST_WORD0;
            end
            nfbch_pkg::ST_WORD0: begin
                n_valid = 1'b1;
                n_res.code_word     = nfbch_pkg::encode_first(r_sub, r_sow[19:12]);
                n_res.word_index    = 4'd0;
                n_res.last          = 1'b0;
                n_res.bad_satellite = 1'b0;
                n_idx   = 4'd1;
                n_state = nfbch_pkg::ST_READ;
            end
            nfbch_pkg::ST_READ: begin
                n_rd_ok = ((r_idx - 4'd1) < r_nwords) && (32'(rd_addr) < STORE_DEPTH);
                n_state = nfbch_pkg::ST_EMIT;
            end
            nfbch_pkg::ST_EMIT: begin
                payload = r_rd_ok ? ram_rdata : '0;
                if (r_idx == 4'd1) begin
                    payload[21:10] = payload[21:10] | r_sow[11:0];
                end
                n_valid = 1'b1;
                n_res.code_word     = nfbch_pkg::encode_word(payload);
                n_res.word_index    = r_idx;
                n_res.last          = (r_idx == nfbch_pkg::LAST_IDX);
                n_res.bad_satellite = 1'b0;
                if (r_idx == nfbch_pkg::LAST_IDX) begin
                    n_state = nfbch_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx + 4'd1;
                    n_state = nfbch_pkg::ST_READ;
                end
            end
            nfbch_pkg::ST_BAD: begin
                n_valid = 1'b1;
                n_res.code_word     = '0;
                n_res.word_index    = 4'd0;
                n_res.last          = 1'b1;
                n_res.bad_satellite = 1'b1;
                n_state = nfbch_pkg::ST_IDLE;
            end
            default: n_state = nfbch_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfbch_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ms     <= n_ms;
        r_d1     <= n_d1;
        r_row    <= n_row;
        r_pass   <= n_pass;
        r_q      <= n_q;
        r_sow    <= n_sow;
        r_sub    <= n_sub;
        r_page   <= n_page;
        r_base   <= n_base;
        r_nwords <= n_nwords;
        r_idx    <= n_idx;
        r_rd_ok  <= n_rd_ok;
        r_res    <= n_res;
    end

    assign o_busy   = (r_state != nfbch_pkg::ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfbch_pkg::ST_CLEAR) |-> !o_valid)
        else $error("result strobe during store clear");
    a_bad_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.bad_satellite) |->
            (o_result.last && o_result.word_index == 4'd0 && o_result.code_word == 30'd0))
        else $error("malformed error transaction");
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |->
            ##2 (o_valid && o_result.word_index == $past(o_result.word_index, 2) + 4'd1))
        else $error("subframe words out of order");
    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.mode == nfbch_pkg::MODE_REQUEST) |=> o_busy)
        else $error("frame request did not raise busy");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == nfbch_pkg::ST_DIV_WAIT))
        else $error("division finished outside wait state");
`endif

endmodule

`default_nettype wire

@@ test/nav_frame_bch_interleave_encoder_test.sv @@
// Testbench for nav_frame_bch_interleave_encoder: store writes and frame requests are
// driven in random bursts, and every emitted code word is checked against a local predictor.
// Depends on nfbch_pkg and the encoder RTL.
`default_nettype none

module nav_frame_bch_interleave_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WEEK_LEN_MS = 604800000;
    localparam int unsigned ALM_BASE    = 1431;
    localparam int unsigned D2_BASE     = 1863;
    localparam logic [59:0] BCH_TAPS    = {15'h7ac0, 15'h3d60, 15'h1eb0, 15'h7590};

    typedef struct {
        nfbch_pkg::t_in_item item;
        bit                  hold;
    } t_stim;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    nfbch_pkg::t_in_item i_in;
    logic                o_busy;
    logic                o_valid;
    nfbch_pkg::t_result  o_result;

    t_stim              stim_q[$];
    nfbch_pkg::t_result word_q[$];
    logic [21:0]        msg_store [4096];
    nfbch_pkg::t_result want;

    int gap_left;
    int burst_left;
    int fail_count;
    int n_writes;
    int n_requests;
    int n_bad;
    int n_checked;
    int n_items;

    nav_frame_bch_interleave_encoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_in     (i_in),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void report_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic logic [14:0] add_parity(input logic [14:0] w);
        for (int k = 0; k < 4; k++) begin
            if (^(w & BCH_TAPS[59-15*k -: 15])) w[3-k] = ~w[3-k];
        end
        return w;
    endfunction

    function automatic logic [29:0] weave(input logic [14:0] hi, input logic [14:0] lo);
        logic [29:0] r;
        for (int k = 0; k < 15; k++) begin
            r[2*k+1] = hi[k];
            r[2*k]   = lo[k];
        end
        return r;
    endfunction

    // subframe, second of week and store window read by one frame request
    function automatic void frame_layout(input logic [29:0] ms_raw, input logic [5:0] sat,
                                         output int unsigned sub, output int unsigned sow,
                                         output int unsigned base, output int unsigned nwords);
        int unsigned ms;
        int unsigned row;
        ms = ms_raw % WEEK_LEN_MS;
        base = 0;
        nwords = 0;
        if (sat >= 6 && sat <= 58) begin
            sow = ms / 1000;
            sub = (sow / 6) % 5 + 1;
            if (sub > 3) base = ALM_BASE + ((sub - 4) * 24 + (sow / 30) % 24) * 9;
            else base = (sat - 6) * 27 + (sub - 1) * 9;
            nwords = 9;
        end else begin
            row = (sat <= 5) ? sat - 1 : sat - 54;
            sow = ms / 3000 * 3;
            sub = (ms / 600) % 5 + 1;
            if (sub == 1) begin
                base = D2_BASE + row * 40 + ((ms / 6000) % 10) * 4;
                nwords = 4;
            end
        end
    endfunction

    function automatic void apply_transaction(input nfbch_pkg::t_in_item it);
        int unsigned sub;
        int unsigned sow;
        int unsigned base;
        int unsigned nwords;
        logic [21:0] payload [1:9];
        logic [29:0] w0;
        nfbch_pkg::t_result r;
        if (it.mode == nfbch_pkg::MODE_WRITE) begin
            msg_store[it.table_addr] = it.table_word;
            n_writes++;
            return;
        end
        n_requests++;
        if (it.sat_id == 6'd0) begin
            r.code_word     = '0;
            r.word_index    = '0;
            r.last          = 1'b1;
            r.bad_satellite = 1'b1;
            word_q.push_back(r);
            n_bad++;
            return;
        end
        frame_layout(it.ms_of_week, it.sat_id, sub, sow, base, nwords);
        for (int i = 1; i <= 9; i++) begin
            payload[i] = (i <= nwords) ? msg_store[base+i-1] : 22'd0;
        end
        payload[1] = payload[1] | 22'((sow & 32'hfff) << 10);
        w0 = {11'h712, 4'b0000, 3'(sub), 8'(sow >> 12), 4'b0000};
        w0[14:0] = add_parity(w0[14:0]);
        r.code_word     = w0;
        r.word_index    = 4'd0;
        r.last          = 1'b0;
        r.bad_satellite = 1'b0;
        word_q.push_back(r);
        for (int i = 1; i <= 9; i++) begin
            r.code_word  = weave(add_parity({payload[i][21:11], 4'b0000}),
                                 add_parity({payload[i][10:0], 4'b0000}));
            r.word_index = 4'(i);
            r.last       = (i == 9);
            word_q.push_back(r);
        end
    endfunction

    function automatic void add_write(input int unsigned addr, input int unsigned word,
                                      input bit hold);
        t_stim s;
        s.item.mode       = nfbch_pkg::MODE_WRITE;
        s.item.table_addr = 12'(addr);
        s.item.table_word = 22'(word);
        s.item.ms_of_week = 30'($urandom);
        s.item.sat_id     = 6'($urandom);
        s.hold = hold;
        stim_q.push_back(s);
        n_items++;
    endfunction

    function automatic void add_request(input logic [29:0] ms, input logic [5:0] sat,
                                        input bit hold);
        t_stim s;
        s.item.mode       = nfbch_pkg::MODE_REQUEST;
        s.item.table_addr = 12'($urandom);
        s.item.table_word = 22'($urandom);
        s.item.ms_of_week = ms;
        s.item.sat_id     = sat;
        s.hold = hold;
        stim_q.push_back(s);
        n_items++;
    endfunction

    function automatic logic [29:0] pick_ms();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 30'($urandom_range(WEEK_LEN_MS, 30'h3fffffff));
        if (r < 25) return 30'($urandom_range(0, 1007999) * 600 + $urandom_range(0, 1));
        return 30'($urandom_range(0, WEEK_LEN_MS - 1));
    endfunction

    // driver: one item on the bus per transaction, bursts separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                i_start <= 1'b0;
            end else if (stim_q.size() != 0 && !(stim_q[0].hold && word_q.size() != 0)) begin
                i_start <= 1'b1;
                i_in    <= stim_q[0].item;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: check results, then record the accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (word_q.size() == 0) begin
                    report_error($sformatf("unexpected result code %h idx %0d last %b bad %b",
                        o_result.code_word, o_result.word_index, o_result.last,
                        o_result.bad_satellite));
                end else begin
                    want = word_q.pop_front();
                    if (o_result.code_word !== want.code_word
                        || o_result.word_index !== want.word_index
                        || o_result.last !== want.last
                        || o_result.bad_satellite !== want.bad_satellite) begin
                        report_error($sformatf(
                            "expected code %h idx %0d last %b bad %b, got %h %0d %b %b",
                            want.code_word, want.word_index, want.last, want.bad_satellite,
                            o_result.code_word, o_result.word_index, o_result.last,
                            o_result.bad_satellite));
                    end
                    n_checked++;
                end
            end
            if (i_start && !o_busy) begin
                apply_transaction(i_in);
                void'(stim_q.pop_front());
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 180)
                                                            : $urandom_range(0, 4);
                end
            end
        end
    end

    initial begin
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned sub;
        int unsigned sow;
        int unsigned base;
        int unsigned nwords;
        int unsigned r;
        logic [29:0] ms;
        logic [5:0]  sat;

        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_in       = '0;
        gap_left   = 0;
        burst_left = 4;
        fail_count = 0;
        n_writes   = 0;
        n_requests = 0;
        n_bad      = 0;
        n_checked  = 0;
        n_items    = 0;
        foreach (msg_store[a]) msg_store[a] = '0;

        // directed: store corners, satellite classes, week wrap, each subframe kind
        add_write(0, 22'h3fffff, 0);
        add_write(4095, 22'h3fffff, 0);
        add_write(ALM_BASE, 22'h155555, 0);
        add_write(2262, 22'h2aaaaa, 0);
        add_write(1, 0, 0);
        add_write(D2_BASE, 22'h3fffff, 0);
        add_request(30'd0, 6'd6, 0);
        add_request(30'd604799999, 6'd58, 0);
        add_request(30'd12345, 6'd0, 0);
        add_request(30'h3fffffff, 6'd0, 0);
        add_request(30'd0, 6'd1, 0);
        add_request(30'd600, 6'd5, 0);
        add_request(30'd604800000, 6'd59, 0);
        add_request(30'h3fffffff, 6'd63, 0);
        add_request(30'd18000, 6'd6, 0);
        add_request(30'd24000, 6'd20, 0);
        add_request(30'd6000, 6'd7, 0);
        add_request(30'd12000, 6'd40, 0);
        add_request(30'd54000, 6'd63, 0);
        add_write(0, 22'h0, 0);
        add_request(30'd0, 6'd6, 1);

        while (n_items < 450) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                ms  = pick_ms();
                sat = 6'($urandom_range(1, 63));
                frame_layout(ms, sat, sub, sow, base, nwords);
                for (int i = 0; i < nwords; i++) begin
                    if ($urandom_range(0, 9) != 0) add_write(base + i, $urandom, 0);
                end
                add_request(ms, sat, $urandom_range(0, 49) == 0);
            end else if (r < 85) begin
                sat = ($urandom_range(0, 19) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
                add_request(pick_ms(), sat, 0);
            end else begin
                add_write($urandom_range(0, 4095), $urandom, 0);
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || word_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Covered %0d store writes and %0d frame requests, %0d of them bad satellites.",
                 n_writes, n_requests, n_bad);
        $display("%0d result transactions compared, %0d errors.", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
